[src/plrw_pkg.sv]
`timescale 1ns / 1ps

package plrw_pkg;

   localparam int unsigned PeriodWidth  = 16;
   localparam int unsigned PercentWidth = 7;
   localparam int unsigned PingsWidth   = 8;
   localparam int unsigned RebootWidth  = 16;
   localparam int unsigned CountWidth   = 16;
   localparam int unsigned SilentWidth  = 3;

   localparam int unsigned CsrAddrWidth = 2;
   localparam int unsigned CsrDataWidth = 16;
   localparam int unsigned ReqWidth     = 8;
   localparam int unsigned RspWidth     = 24;

   localparam logic [SilentWidth-1:0] SilentLimit  = SilentWidth'(5);
   localparam logic [PingsWidth-1:0]  PercentBase  = PingsWidth'(100);
   localparam logic [CountWidth-1:0]  RoundStart   = CountWidth'(9999);

   localparam logic [PeriodWidth-1:0]  PeriodReset  = PeriodWidth'(300);
   localparam logic [PercentWidth-1:0] PercentReset = PercentWidth'(10);
   localparam logic [PingsWidth-1:0]   PingsReset   = PingsWidth'(10);
   localparam logic [RebootWidth-1:0]  RebootReset  = RebootWidth'(60);

   typedef enum logic [CsrAddrWidth-1:0] {
      CSR_PING_PERIOD     = 2'd0,
      CSR_LOSS_PERCENT    = 2'd1,
      CSR_PINGS_PER_ROUND = 2'd2,
      CSR_REBOOT_SECONDS  = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [PeriodWidth-1:0]  ping_period_seconds;
      logic [PercentWidth-1:0] loss_percent;
      logic [PingsWidth-1:0]   pings_per_round;
      logic [RebootWidth-1:0]  reboot_seconds;
   } cfg_type;

   typedef struct packed {
      logic [CountWidth-1:0]  seconds_in_round;
      logic [PingsWidth-1:0]  pings_counted;
      logic [PingsWidth-1:0]  misses_counted;
      logic [SilentWidth-1:0] silent_seconds;
      logic                   first_ping_pending;
      logic                   reboot_active;
      logic [RebootWidth-1:0] reboot_elapsed;
      logic [CountWidth-1:0]  reboot_count;
      logic                   lamp;
      logic                   visible_flag;
      logic                   relay;
   } state_type;

   typedef struct packed {
      logic                  send_ping;
      logic                  led_on;
      logic                  target_visible;
      logic                  relay_on;
      logic [CountWidth-1:0] reboot_total;
   } result_type;

endpackage

[src/ping_loss_reboot_watchdog.sv]
`timescale 1ns / 1ps
// A word accepted at a clock edge has its result registered and on rsp_tdata after that edge.
// Throughput: one word per cycle; the output register frees as it is taken, so input
// is stalled only while a result waits on rsp_tready.
// Reset: synchronous, active high; clears round, reboot and lamp state but presets
// seconds_in_round to 9999, loads register defaults and empties the output register.
module ping_loss_reboot_watchdog (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_tvalid,
   output logic                                 req_tready,
   // [0] second_tick, [1] answer_seen, [7:2] zero
   input  logic [plrw_pkg::ReqWidth-1:0]        req_tdata,
   output logic                                 rsp_tvalid,
   input  logic                                 rsp_tready,
   // [0] send_ping, [1] led_on, [2] target_visible, [3] relay_on,
   // [19:4] reboot_total, [23:20] zero
   output logic [plrw_pkg::RspWidth-1:0]        rsp_tdata,
   input  logic                                 csr_we,
   input  logic [plrw_pkg::CsrAddrWidth-1:0]    csr_addr,
   input  logic [plrw_pkg::CsrDataWidth-1:0]    csr_wdata
);
   import plrw_pkg::*;

   cfg_type    cfg;
   state_type  state_ff;
   state_type  state_in;
   result_type result_in;
   result_type result_ff;
   logic       rsp_valid_ff;
   logic       req_accept;

   plrw_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   plrw_step u_step (
      .cfg         (cfg),
      .state       (state_ff),
      .second_tick (req_tdata[0]),
      .answer_seen (req_tdata[1]),
      .state_next  (state_in),
      .result      (result_in)
   );

   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.seconds_in_round   <= RoundStart;
         state_ff.pings_counted      <= '0;
         state_ff.misses_counted     <= '0;
         state_ff.silent_seconds     <= '0;
         state_ff.first_ping_pending <= 1'b1;
         state_ff.reboot_active      <= 1'b0;
         state_ff.reboot_elapsed     <= '0;
         state_ff.reboot_count       <= '0;
         state_ff.lamp               <= 1'b0;
         state_ff.visible_flag       <= 1'b0;
         state_ff.relay              <= 1'b0;
         rsp_valid_ff                <= 1'b0;
      end else begin
         if (req_accept) begin
            state_ff     <= state_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         result_ff <= result_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {4'b0, result_ff.reboot_total, result_ff.relay_on,
                        result_ff.target_visible, result_ff.led_on, result_ff.send_ping};

   a_relay_only_in_reboot: assert property (@(posedge clock) disable iff (reset)
      state_ff.relay |-> state_ff.reboot_active)
      else $error("relay driven outside a reboot phase");

   a_silent_below_limit: assert property (@(posedge clock) disable iff (reset)
      state_ff.silent_seconds < SilentLimit)
      else $error("silent second count reached the miss limit");

   a_counter_needs_word: assert property (@(posedge clock) disable iff (reset)
      !req_accept |=> $stable(state_ff.reboot_count))
      else $error("reboot count moved without an input word");

   a_accept_gives_result: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> rsp_tvalid)
      else $error("accepted word produced no result");

endmodule

[src/plrw_csr.sv]
`timescale 1ns / 1ps

module plrw_csr (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [plrw_pkg::CsrAddrWidth-1:0]    csr_addr,
   input  logic [plrw_pkg::CsrDataWidth-1:0]    csr_wdata,
   output plrw_pkg::cfg_type                    cfg
);
   import plrw_pkg::*;

   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.ping_period_seconds <= PeriodReset;
         cfg_ff.loss_percent        <= PercentReset;
         cfg_ff.pings_per_round     <= PingsReset;
         cfg_ff.reboot_seconds      <= RebootReset;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_addr))
            CSR_PING_PERIOD: begin
               cfg_ff.ping_period_seconds <= csr_wdata[PeriodWidth-1:0];
            end
            CSR_LOSS_PERCENT: begin
               cfg_ff.loss_percent <= csr_wdata[PercentWidth-1:0];
            end
            CSR_PINGS_PER_ROUND: begin
               cfg_ff.pings_per_round <= csr_wdata[PingsWidth-1:0];
            end
            CSR_REBOOT_SECONDS: begin
               cfg_ff.reboot_seconds <= csr_wdata[RebootWidth-1:0];
            end
            default: begin
            end
         endcase
      end
   end

   assign cfg = cfg_ff;

endmodule

[src/plrw_step.sv]
`timescale 1ns / 1ps

module plrw_step (
   input  plrw_pkg::cfg_type    cfg,
   input  plrw_pkg::state_type  state,
   input  logic                 second_tick,
   input  logic                 answer_seen,
   output plrw_pkg::state_type  state_next,
   output plrw_pkg::result_type result
);
   import plrw_pkg::*;

   state_type              s;
   logic                   send;
   logic [SilentWidth-1:0] silent_inc;
   logic [14:0]            allowed_scaled;
   logic [14:0]            missed_scaled;

   // misses > floor(p*l/100)  <=>  p*l < 100*misses
   assign allowed_scaled = 15'(cfg.pings_per_round) * 15'(cfg.loss_percent);
   assign missed_scaled  = 15'(state.misses_counted) * 15'(PercentBase);

   always_comb begin
      s          = state;
      send       = 1'b0;
      silent_inc = '0;

      if (s.reboot_active) begin
         if (second_tick && s.reboot_elapsed != '1) begin
            s.reboot_elapsed = s.reboot_elapsed + 1'b1;
         end
         if (s.reboot_elapsed >= cfg.reboot_seconds) begin
            s.relay         = 1'b0;
            s.reboot_active = 1'b0;
         end else if (cfg.reboot_seconds != '0) begin
            s.relay = 1'b1;
         end
      end

      if (second_tick) begin
         if (s.seconds_in_round != '1) begin
            s.seconds_in_round = s.seconds_in_round + 1'b1;
         end

         // round complete
         if (s.pings_counted >= cfg.pings_per_round) begin
            if (allowed_scaled < missed_scaled) begin
               s.reboot_active  = 1'b1;
               s.reboot_elapsed = '0;
               s.reboot_count   = s.reboot_count + 1'b1;
            end
            s.seconds_in_round   = '0;
            s.pings_counted      = '0;
            s.first_ping_pending = 1'b1;
            s.misses_counted     = '0;
         end

         if (s.seconds_in_round > cfg.ping_period_seconds) begin
            if (s.first_ping_pending) begin
               s.first_ping_pending = 1'b0;
               send                 = 1'b1;
            end else if (answer_seen) begin
               s.silent_seconds = '0;
               s.lamp           = 1'b1;
               s.visible_flag   = 1'b1;
               if (s.pings_counted != '1) begin
                  s.pings_counted = s.pings_counted + 1'b1;
               end
               send = 1'b1;
            end else begin
               silent_inc = (s.silent_seconds != '1) ? s.silent_seconds + 1'b1
                                                     : s.silent_seconds;
               if (silent_inc >= SilentLimit) begin
                  s.lamp           = 1'b0;
                  s.visible_flag   = 1'b0;
                  s.silent_seconds = '0;
                  if (s.misses_counted != '1) begin
                     s.misses_counted = s.misses_counted + 1'b1;
                  end
                  if (s.pings_counted != '1) begin
                     s.pings_counted = s.pings_counted + 1'b1;
                  end
                  send = 1'b1;
               end else begin
                  s.silent_seconds = silent_inc;
               end
            end
         end
      end
   end

   assign state_next            = s;
   assign result.send_ping      = send;
   assign result.led_on         = s.lamp;
   assign result.target_visible = s.visible_flag;
   assign result.relay_on       = s.relay;
   assign result.reboot_total   = s.reboot_count;

endmodule
